### rtl/mkmr_pkg.sv
// Shared constants, register codes and widths of the mouse key motion reporter.
// Used by the channel interfaces, the top level and the port checker; no dependencies.
`timescale 1ns / 1ps

package mkmr_pkg;

    // Integral width default and fixed field widths.
    localparam int SUM_WIDTH_DEF = 32;
    localparam int TICKS_W       = 17;
    localparam int IVL_W         = 16;
    localparam int DIV_W         = 16;
    localparam int STEP_W        = 7;
    localparam int DELTA_W       = 8;
    localparam int KEYS_W        = 4;

    // Quotient magnitude bits below the clamp check, and the step counter that walks them.
    localparam int Q_W   = 7;
    localparam int CNT_W = $clog2(Q_W + 1);

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MOVE_MODE        = 3'd0,
        CFG_MOVE_INTERVAL    = 3'd1,
        CFG_INTEGRAL_DIVISOR = 3'd2,
        CFG_WHEEL_MODE       = 3'd3,
        CFG_WHEEL_STEP       = 3'd4,
        CFG_WHEEL_INTERVAL   = 3'd5
    } t_cfg_idx;

    // Register reset values.
    localparam logic [IVL_W-1:0]  RST_MOVE_INTERVAL  = 16'd10;
    localparam logic [DIV_W-1:0]  RST_DIVISOR        = 16'd16;
    localparam logic [STEP_W-1:0] RST_WHEEL_STEP     = 7'd1;
    localparam logic [IVL_W-1:0]  RST_WHEEL_INTERVAL = 16'd20;

    // Key bit positions, shared by movement and wheel keys.
    localparam int KEY_UP    = 0;
    localparam int KEY_DOWN  = 1;
    localparam int KEY_LEFT  = 2;
    localparam int KEY_RIGHT = 3;

    // Largest reported magnitude.
    localparam logic [Q_W-1:0] DELTA_MAG_MAX = 7'd127;

endpackage

### rtl/mkmr_if.sv
// Valid/ready channel interfaces for scan-tick words, report words and register writes.
// Depends on mkmr_pkg for the field widths.
`timescale 1ns / 1ps

interface mkmr_in_if;
    logic                              valid;
    logic                              ready;
    logic                              mouse_layer_active;
    logic [mkmr_pkg::KEYS_W-1:0]       move_keys;
    logic [mkmr_pkg::KEYS_W-1:0]       wheel_keys;

    modport source (output valid, mouse_layer_active, move_keys, wheel_keys, input ready);
    modport sink   (input valid, mouse_layer_active, move_keys, wheel_keys, output ready);
endinterface

interface mkmr_out_if;
    logic                               valid;
    logic                               ready;
    logic                               mouse_report;
    logic                               x_valid;
    logic signed [mkmr_pkg::DELTA_W-1:0] x_delta;
    logic                               y_valid;
    logic signed [mkmr_pkg::DELTA_W-1:0] y_delta;
    logic                               wheel_report;
    logic                               vertical_valid;
    logic signed [mkmr_pkg::DELTA_W-1:0] vertical_delta;
    logic                               horizontal_valid;
    logic signed [mkmr_pkg::DELTA_W-1:0] horizontal_delta;

    modport source (output valid, mouse_report, x_valid, x_delta, y_valid, y_delta,
                    wheel_report, vertical_valid, vertical_delta, horizontal_valid,
                    horizontal_delta, input ready);
    modport sink   (input valid, mouse_report, x_valid, x_delta, y_valid, y_delta,
                    wheel_report, vertical_valid, vertical_delta, horizontal_valid,
                    horizontal_delta, output ready);
endinterface

interface mkmr_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [mkmr_pkg::CFG_IDX_W-1:0]    index;
    logic [mkmr_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/mouse_key_motion_reporter_top.sv
// Mouse key motion reporter: turns held movement and wheel keys into mouse and wheel reports.
// Depends on mkmr_pkg and the channel interfaces in mkmr_if.sv.
// Each tick word passes the integral update and the interval counters, then the shared
// divider for each movement axis that reports, which stops at its first step when the delta
// clamps. One word is in work at a time: the next tick is taken once the report word is
// loaded, later while an earlier one waits on the receiver. Reset is synchronous, active low;
// it restores the register defaults and clears integrals, held flags and interval counters.
`timescale 1ns / 1ps

module mouse_key_motion_reporter_top #(
    parameter int SUM_WIDTH = mkmr_pkg::SUM_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mkmr_in_if.sink      i_in,
    mkmr_out_if.source   o_out,
    mkmr_cfg_if.sink     i_cfg
);

    // The remainder has to hold both the integral magnitude and the divisor shifted to the
    // clamp position.
    localparam int REM_W = (SUM_WIDTH > mkmr_pkg::DIV_W + mkmr_pkg::Q_W) ?
                           SUM_WIDTH : mkmr_pkg::DIV_W + mkmr_pkg::Q_W;

    localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    localparam logic [mkmr_pkg::CNT_W-1:0] STEP_CLAMP = mkmr_pkg::CNT_W'(mkmr_pkg::Q_W);

    // Sequencer: latch the tick, update the integrals, run the interval counters, then divide
    // the x and the y integral in turn on the shared unit, and finally hand over the report.
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_UPD  = 6'b000010,
        S_TICK = 6'b000100,
        S_LOAD = 6'b001000,
        S_DIV  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic                            r_move_mode;
    logic [mkmr_pkg::IVL_W-1:0]      r_move_interval;
    logic [mkmr_pkg::DIV_W-1:0]      r_divisor;
    logic                            r_wheel_mode;
    logic [mkmr_pkg::STEP_W-1:0]     r_wheel_step;
    logic [mkmr_pkg::IVL_W-1:0]      r_wheel_interval;

    // Tick word held while it is in work.
    logic                            r_layer;
    logic [mkmr_pkg::KEYS_W-1:0]     r_mkeys;
    logic [mkmr_pkg::KEYS_W-1:0]     r_wkeys;

    // Integrals, held wheel keys and interval counters.
    logic signed [SUM_WIDTH-1:0]     r_ud_sum;
    logic signed [SUM_WIDTH-1:0]     r_lr_sum;
    logic [mkmr_pkg::KEYS_W-1:0]     r_wheel_held;
    logic [mkmr_pkg::TICKS_W-1:0]    r_x_ticks;
    logic [mkmr_pkg::TICKS_W-1:0]    r_y_ticks;
    logic [mkmr_pkg::TICKS_W-1:0]    r_v_ticks;
    logic [mkmr_pkg::TICKS_W-1:0]    r_h_ticks;

    // Report flags of the current tick and the movement deltas.
    logic                            r_xv;
    logic                            r_yv;
    logic                            r_vv;
    logic                            r_hv;
    logic [mkmr_pkg::DELTA_W-1:0]    r_xd;
    logic [mkmr_pkg::DELTA_W-1:0]    r_yd;

    // Divider state: axis in work (0 for x, 1 for y), quotient bit, remainder, quotient, sign.
    logic                            r_axis;
    logic [mkmr_pkg::CNT_W-1:0]      r_step;
    logic [REM_W-1:0]                r_rem;
    logic [mkmr_pkg::Q_W-1:0]        r_quo;
    logic                            r_neg;

    // Output register.
    logic                            r_out_valid;
    logic                            r_out_xv;
    logic [mkmr_pkg::DELTA_W-1:0]    r_out_xd;
    logic                            r_out_yv;
    logic [mkmr_pkg::DELTA_W-1:0]    r_out_yd;
    logic                            r_out_vv;
    logic [mkmr_pkg::DELTA_W-1:0]    r_out_vd;
    logic                            r_out_hv;
    logic [mkmr_pkg::DELTA_W-1:0]    r_out_hd;

    // Shared divide unit and its next values.
    logic signed [SUM_WIDTH-1:0]     w_sel_sum;
    logic                            w_sel_neg;
    logic [SUM_WIDTH-1:0]            w_sel_mag;
    logic                            w_sel_valid;
    logic [REM_W-1:0]                w_dsh;
    logic                            w_ge;
    logic [REM_W-1:0]                w_diff;
    logic [mkmr_pkg::Q_W-1:0]        n_quo;
    logic                            n_fin;
    logic [mkmr_pkg::DELTA_W-1:0]    w_qx;
    logic [mkmr_pkg::DELTA_W-1:0]    n_delta;

    // Wheel deltas, formed straight from the held keys and the step size.
    logic [mkmr_pkg::DELTA_W-1:0]    w_step_pos;
    logic [mkmr_pkg::DELTA_W-1:0]    w_step_neg;
    logic [mkmr_pkg::DELTA_W-1:0]    w_vd;
    logic [mkmr_pkg::DELTA_W-1:0]    w_hd;

    logic                            w_in_acc;
    logic                            w_out_free;
    logic                            w_out_load;

    // A single step of an integral that sticks at the ends of its range. Opposite keys cancel.
    function automatic logic signed [SUM_WIDTH-1:0] f_sat_step(
        input logic signed [SUM_WIDTH-1:0] sum,
        input logic                        inc,
        input logic                        dec
    );
        logic signed [SUM_WIDTH-1:0] res;
        res = sum;
        if (inc && !dec && (sum != SUM_MAX)) begin
            res = sum + SUM_WIDTH'(1);
        end else if (dec && !inc && (sum != SUM_MIN)) begin
            res = sum - SUM_WIDTH'(1);
        end
        return res;
    endfunction

    // Interval counter of one axis: returns {report, next count}. An idle axis restarts at
    // zero; an active one reports once it has passed the interval, and otherwise counts up
    // until it sticks at its top value.
    function automatic logic [mkmr_pkg::TICKS_W:0] f_axis(
        input logic                         active,
        input logic [mkmr_pkg::TICKS_W-1:0] ticks,
        input logic [mkmr_pkg::IVL_W-1:0]   interval
    );
        logic [mkmr_pkg::TICKS_W:0] res;
        res = '0;
        if (!active) begin
            res = '0;
        end else if (ticks > mkmr_pkg::TICKS_W'(interval)) begin
            res = {1'b1, {mkmr_pkg::TICKS_W{1'b0}}};
        end else if (ticks != {mkmr_pkg::TICKS_W{1'b1}}) begin
            res = {1'b0, ticks + mkmr_pkg::TICKS_W'(1)};
        end else begin
            res = {1'b0, ticks};
        end
        return res;
    endfunction

    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_out_load = (r_state == S_DONE) && w_out_free;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    // The axis in work picks its integral; the divider works on its magnitude and puts the
    // sign back at the end, which truncates toward zero.
    assign w_sel_sum   = r_axis ? r_ud_sum : r_lr_sum;
    assign w_sel_neg   = w_sel_sum[SUM_WIDTH-1];
    assign w_sel_mag   = w_sel_neg ? (~w_sel_sum + SUM_WIDTH'(1)) : w_sel_sum;
    assign w_sel_valid = r_axis ? r_yv : r_xv;

    // One restoring step per cycle. The first step compares against the divisor shifted to
    // the clamp position: if the magnitude reaches it, the quotient is at least 128 and the
    // delta clamps to 127. A zero divisor always lands there, which gives the full-scale
    // answer with the sign of the integral.
    assign w_dsh  = REM_W'(r_divisor) << r_step;
    assign w_ge   = (r_rem >= w_dsh);
    assign w_diff = r_rem - w_dsh;

    always_comb begin
        if (r_step == STEP_CLAMP) begin
            n_quo = w_ge ? mkmr_pkg::DELTA_MAG_MAX : '0;
            n_fin = w_ge;
        end else begin
            n_quo = r_quo | (w_ge ? (mkmr_pkg::Q_W'(1) << r_step) : '0);
            n_fin = (r_step == '0);
        end
        w_qx    = {1'b0, n_quo};
        n_delta = r_neg ? (~w_qx + mkmr_pkg::DELTA_W'(1)) : w_qx;
    end

    // Up or left held gives a positive wheel step, otherwise a negative one.
    assign w_step_pos = {1'b0, r_wheel_step};
    assign w_step_neg = ~w_step_pos + mkmr_pkg::DELTA_W'(1);
    assign w_vd = !r_vv ? '0 : (r_wheel_held[mkmr_pkg::KEY_UP]   ? w_step_pos : w_step_neg);
    assign w_hd = !r_hv ? '0 : (r_wheel_held[mkmr_pkg::KEY_LEFT] ? w_step_pos : w_step_neg);

    // Register writes land in any cycle unchecked; the user must send them only while idle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_move_mode      <= 1'b0;
            r_move_interval  <= mkmr_pkg::RST_MOVE_INTERVAL;
            r_divisor        <= mkmr_pkg::RST_DIVISOR;
            r_wheel_mode     <= 1'b0;
            r_wheel_step     <= mkmr_pkg::RST_WHEEL_STEP;
            r_wheel_interval <= mkmr_pkg::RST_WHEEL_INTERVAL;
        end else if (i_cfg.valid) begin
            unique case (mkmr_pkg::t_cfg_idx'(i_cfg.index))
                mkmr_pkg::CFG_MOVE_MODE:        r_move_mode      <= i_cfg.data[0];
                mkmr_pkg::CFG_MOVE_INTERVAL:    r_move_interval  <= i_cfg.data;
                mkmr_pkg::CFG_INTEGRAL_DIVISOR: r_divisor        <= i_cfg.data;
                mkmr_pkg::CFG_WHEEL_MODE:       r_wheel_mode     <= i_cfg.data[0];
                mkmr_pkg::CFG_WHEEL_STEP:       r_wheel_step     <= i_cfg.data[mkmr_pkg::STEP_W-1:0];
                mkmr_pkg::CFG_WHEEL_INTERVAL:   r_wheel_interval <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // Sequencer, state update and shared divider.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ud_sum     <= '0;
            r_lr_sum     <= '0;
            r_wheel_held <= '0;
            r_x_ticks    <= '0;
            r_y_ticks    <= '0;
            r_v_ticks    <= '0;
            r_h_ticks    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            // A new report word takes the output register; otherwise a taken one leaves it.
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_layer <= i_in.mouse_layer_active;
                        r_mkeys <= i_in.move_keys;
                        r_wkeys <= i_in.wheel_keys;
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    // Leaving the mouse layer drops both integrals and the held wheel keys.
                    if (r_layer) begin
                        r_ud_sum <= f_sat_step(r_ud_sum, r_mkeys[mkmr_pkg::KEY_UP],
                                               r_mkeys[mkmr_pkg::KEY_DOWN]);
                        r_lr_sum <= f_sat_step(r_lr_sum, r_mkeys[mkmr_pkg::KEY_LEFT],
                                               r_mkeys[mkmr_pkg::KEY_RIGHT]);
                        r_wheel_held <= r_wkeys;
                    end else begin
                        r_ud_sum     <= '0;
                        r_lr_sum     <= '0;
                        r_wheel_held <= '0;
                    end
                    r_state <= S_TICK;
                end
                S_TICK: begin
                    // A disabled group keeps its counters and reports nothing.
                    if (!r_move_mode) begin
                        {r_xv, r_x_ticks} <= f_axis(r_lr_sum != '0, r_x_ticks, r_move_interval);
                        {r_yv, r_y_ticks} <= f_axis(r_ud_sum != '0, r_y_ticks, r_move_interval);
                    end else begin
                        r_xv <= 1'b0;
                        r_yv <= 1'b0;
                    end
                    if (!r_wheel_mode) begin
                        {r_vv, r_v_ticks} <= f_axis(r_wheel_held[mkmr_pkg::KEY_UP] ||
                                                    r_wheel_held[mkmr_pkg::KEY_DOWN],
                                                    r_v_ticks, r_wheel_interval);
                        {r_hv, r_h_ticks} <= f_axis(r_wheel_held[mkmr_pkg::KEY_LEFT] ||
                                                    r_wheel_held[mkmr_pkg::KEY_RIGHT],
                                                    r_h_ticks, r_wheel_interval);
                    end else begin
                        r_vv <= 1'b0;
                        r_hv <= 1'b0;
                    end
                    r_axis  <= 1'b0;
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    if (w_sel_valid) begin
                        r_rem   <= REM_W'(w_sel_mag);
                        r_neg   <= w_sel_neg;
                        r_quo   <= '0;
                        r_step  <= STEP_CLAMP;
                        r_state <= S_DIV;
                    end else begin
                        // An axis that does not report carries a zero delta.
                        if (r_axis) begin
                            r_yd    <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_xd    <= '0;
                            r_axis  <= 1'b1;
                        end
                    end
                end
                S_DIV: begin
                    if (w_ge && (r_step != STEP_CLAMP)) begin
                        r_rem <= w_diff;
                    end
                    r_quo  <= n_quo;
                    r_step <= r_step - mkmr_pkg::CNT_W'(1);
                    if (n_fin) begin
                        if (r_axis) begin
                            r_yd    <= n_delta;
                            r_state <= S_DONE;
                        end else begin
                            r_xd    <= n_delta;
                            r_axis  <= 1'b1;
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_DONE: begin
                    // Wait here only while an earlier report word is still not taken.
                    if (w_out_free) begin
                        r_out_xv    <= r_xv;
                        r_out_xd    <= r_xd;
                        r_out_yv    <= r_yv;
                        r_out_yd    <= r_yd;
                        r_out_vv    <= r_vv;
                        r_out_vd    <= w_vd;
                        r_out_hv    <= r_hv;
                        r_out_hd    <= w_hd;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.mouse_report     = r_out_xv || r_out_yv;
    assign o_out.x_valid          = r_out_xv;
    assign o_out.x_delta          = r_out_xd;
    assign o_out.y_valid          = r_out_yv;
    assign o_out.y_delta          = r_out_yd;
    assign o_out.wheel_report     = r_out_vv || r_out_hv;
    assign o_out.vertical_valid   = r_out_vv;
    assign o_out.vertical_delta   = r_out_vd;
    assign o_out.horizontal_valid = r_out_hv;
    assign o_out.horizontal_delta = r_out_hd;

endmodule

### rtl/mkmr_checker.sv
// Port checker for the mouse key motion reporter, bound to the top level.
// Depends on mkmr_pkg for the delta width.
`timescale 1ns / 1ps

module mkmr_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               i_in_ready,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic                               i_mouse_report,
    input logic                               i_x_valid,
    input logic signed [mkmr_pkg::DELTA_W-1:0] i_x_delta,
    input logic                               i_y_valid,
    input logic signed [mkmr_pkg::DELTA_W-1:0] i_y_delta,
    input logic                               i_wheel_report,
    input logic                               i_vertical_valid,
    input logic signed [mkmr_pkg::DELTA_W-1:0] i_vertical_delta,
    input logic                               i_horizontal_valid,
    input logic signed [mkmr_pkg::DELTA_W-1:0] i_horizontal_delta
);

    localparam logic [mkmr_pkg::DELTA_W-1:0] DELTA_MOST_NEG = {1'b1, {(mkmr_pkg::DELTA_W-1){1'b0}}};

    // A stalled report word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_x_delta) &&
        $stable(i_y_delta) && $stable(i_vertical_delta) && $stable(i_horizontal_delta))
        else $error("report word changed while stalled");

    // The block works on one tick at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("tick word taken while the previous one is in work");

    // Summary flags follow the axis flags.
    a_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_mouse_report == (i_x_valid || i_y_valid)) &&
        (i_wheel_report == (i_vertical_valid || i_horizontal_valid)))
        else $error("report summary flag disagrees with axis flags");

    // An axis that did not report carries zero.
    a_zero_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_x_valid || i_x_delta == '0) && (i_y_valid || i_y_delta == '0) &&
        (i_vertical_valid || i_vertical_delta == '0) &&
        (i_horizontal_valid || i_horizontal_delta == '0))
        else $error("unreported axis carries a nonzero delta");

    // Deltas stay inside plus or minus 127.
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_x_delta != DELTA_MOST_NEG) && (i_y_delta != DELTA_MOST_NEG) &&
        (i_vertical_delta != DELTA_MOST_NEG) && (i_horizontal_delta != DELTA_MOST_NEG))
        else $error("delta outside the clamp range");

endmodule

bind mouse_key_motion_reporter_top mkmr_checker u_mkmr_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in.valid),
    .i_in_ready         (i_in.ready),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_mouse_report     (o_out.mouse_report),
    .i_x_valid          (o_out.x_valid),
    .i_x_delta          (o_out.x_delta),
    .i_y_valid          (o_out.y_valid),
    .i_y_delta          (o_out.y_delta),
    .i_wheel_report     (o_out.wheel_report),
    .i_vertical_valid   (o_out.vertical_valid),
    .i_vertical_delta   (o_out.vertical_delta),
    .i_horizontal_valid (o_out.horizontal_valid),
    .i_horizontal_delta (o_out.horizontal_delta)
);
